// ----- hw/rtl/p2c_scan_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2c_scan_pkg: shared definitions for the polar to Cartesian scan unit
// Field widths, register indexes, angle constants and the CORDIC arctangent
// table.
// ----------------------------------------------------------------------------
package p2c_scan_pkg;

	// Sizing
	localparam int MAX_POINTS   = 4096;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;
	localparam int STEPS        = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int STEP_W       = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int TAB_IDX_W    = $clog2(TABLE_LEN);

	// Field widths
	localparam int ANGLE_W   = 17;
	localparam int RANGE_W   = 16;
	localparam int COORD_W   = 17;
	localparam int INDEX_W   = 12;
	localparam int COUNT_W   = 13;

	// Stream and configuration port widths
	localparam int S_TDATA_W  = 16;
	localparam int M_FIELDS_W = 2 * COORD_W + INDEX_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 17;

	// Interpolation divider: divisor is point count minus one
	localparam int DIV_W      = $clog2(MAX_POINTS);
	localparam int IDX_CMP_W  = (DIV_W > INDEX_W) ? DIV_W : INDEX_W;
	localparam int DIFF_W     = ANGLE_W + 1;
	localparam int QUO_W      = ANGLE_W;
	localparam int PROD_W     = QUO_W + DIV_W;
	localparam int DIV_CNT_W  = $clog2(QUO_W);

	// Angle and rotation datapath widths
	localparam int Z_W        = 34;
	localparam int XY_W       = 48;
	localparam int GAIN_W     = 30;
	localparam int FRAC_SH    = 30;

	// Angle constants, 2^30 per radian
	localparam logic signed [Z_W-1:0] ANG_PI      = 34'sd3373259426;
	localparam logic signed [Z_W-1:0] ANG_HALF_PI = 34'sd1686629713;
	localparam logic signed [Z_W-1:0] ANG_TWO_PI  = 34'sd6746518852;

	// CORDIC gain compensation, Q0.30
	localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

	// Output saturation bound
	localparam int OUT_LIMIT = 65535;

	// Configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_START_ANGLE = 2'd0,
		CFG_END_ANGLE   = 2'd1,
		CFG_POINT_COUNT = 2'd2
	} cfg_reg_t;

	// Sequencer states, one-hot
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_DIV  = 7'b0000100,
		ST_ANG  = 7'b0001000,
		ST_WRAP = 7'b0010000,
		ST_FOLD = 7'b0100000,
		ST_ROT  = 7'b1000000
	} state_t;

	// atan(2^-k), Q.30, truncated
	localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
		32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
		32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
		32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

endpackage

// ----- hw/rtl/polar_to_cartesian_scan_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_to_cartesian_scan_unit: laser scan range samples to Cartesian points
// Interpolates the sample angle across the scan, reduces it to [-pi/2, pi/2]
// and rotates the range vector with an iterative CORDIC.
//
//   channel  | dir | tdata (low bit up)                      | tlast
//   ---------+-----+-----------------------------------------+-----------
//   s_axis   | in  | range_value[15:0]                       | scan_end
//   m_axis   | out | x_coord, y_coord, sample_index, 2'b0    | last_point
//   cfg      | in  | cfg_index selects register, cfg_data    | -
//
// One transaction in gives one transaction out; no new sample is taken
// until the finished point has been loaded into the output register.
// The sample period is set by the bit-serial interpolation divider (17
// quotient bits, one per cycle) and the CORDIC stage (CORDIC_STEPS rotations).
// A finished point waits in the output register; a stall there holds the
// sequencer before it loads the next point. Reset clears all control state.
// ----------------------------------------------------------------------------
module polar_to_cartesian_scan_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_wr_en,
	input  logic [p2c_scan_pkg::CFG_ADDR_W-1:0]   cfg_index,
	input  logic [p2c_scan_pkg::CFG_DATA_W-1:0]   cfg_data,
	// range samples
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [p2c_scan_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // range_value
	input  logic                                  s_axis_tlast,  // scan_end
	// points
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [p2c_scan_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // x_coord, y_coord, sample_index, pad
	output logic                                  m_axis_tlast   // last_point
);
	import p2c_scan_pkg::*;

	localparam int RN_W  = XY_W - FRAC_SH + 2;
	localparam int PAD_W = M_TDATA_W - M_FIELDS_W;
	localparam logic signed [RN_W-1:0]  LIM_P = RN_W'(OUT_LIMIT);
	localparam logic signed [RN_W-1:0]  LIM_N = -LIM_P;
	localparam logic signed [XY_W:0]    RND   = (XY_W+1)'(1) <<< (FRAC_SH - 1);
	localparam logic [COUNT_W:0]        CNT_MAX = (COUNT_W+1)'(MAX_POINTS);

	// Round to signed Q17.0, apply fold negation, saturate
	function automatic logic [COORD_W-1:0] to_out(input logic signed [XY_W-1:0] v,
			input logic neg);
		logic signed [XY_W:0]   t;
		logic signed [RN_W-1:0] r;
		logic signed [RN_W-1:0] rn;
		t  = $signed({v[XY_W-1], v}) + RND;
		r  = $signed({t[XY_W], t[XY_W:FRAC_SH]});
		rn = neg ? -r : r;
		if (rn > LIM_P)
			rn = LIM_P;
		else if (rn < LIM_N)
			rn = LIM_N;
		return rn[COORD_W-1:0];
	endfunction

	// Configuration registers and scan index counter
	logic signed [ANGLE_W-1:0] start_q, end_q;
	logic [COUNT_W-1:0]        count_q;
	logic [INDEX_W-1:0]        index_counter_q;

	state_t state_q;

	// Per-sample registers
	logic [RANGE_W-1:0]        range_q;
	logic                      last_q;
	logic [INDEX_W-1:0]        cnt_q;
	logic [DIV_W-1:0]          i_q;
	logic [DIV_W-1:0]          d_q;
	logic                      prod_neg_q;
	logic [DIV_W-1:0]          rem_q;
	logic [QUO_W-1:0]          dvd_q;
	logic [QUO_W-1:0]          quo_q;
	logic [DIV_CNT_W-1:0]      div_cnt_q;
	logic signed [ANGLE_W-1:0] theta_q;
	logic signed [Z_W-1:0]     z_q;
	logic                      fold_neg_q;
	logic signed [XY_W-1:0]    x_q, y_q;
	logic [STEP_W-1:0]         step_q;

	// Output register
	logic                      m_valid_q;
	logic [COORD_W-1:0]        m_x_q, m_y_q;
	logic [INDEX_W-1:0]        m_idx_q;
	logic                      m_last_q;

	logic s_fire, out_free, out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign out_load      = (state_q == ST_ROT) && (step_q == STEP_W'(STEPS - 1)) && out_free;

	// Clamped point count minus one, and interpolation index
	logic [DIV_W-1:0]     n_m1;
	logic [IDX_CMP_W-1:0] cnt_ext, nm1_ext;
	always_comb begin
		if (count_q == '0)
			n_m1 = '0;
		else if ({1'b0, count_q} > CNT_MAX)
			n_m1 = DIV_W'(MAX_POINTS - 1);
		else
			n_m1 = DIV_W'(count_q - COUNT_W'(1));
		cnt_ext = IDX_CMP_W'(index_counter_q);
		nm1_ext = IDX_CMP_W'(n_m1);
	end

	// Angle difference times index
	logic signed [DIFF_W-1:0]      diff;
	logic signed [DIFF_W+DIV_W:0]  prod;
	logic [DIFF_W+DIV_W:0]         prod_mag;
	always_comb begin
		diff     = $signed({end_q[ANGLE_W-1], end_q}) - $signed({start_q[ANGLE_W-1], start_q});
		prod     = diff * $signed({1'b0, i_q});
		prod_mag = prod[DIFF_W+DIV_W] ? -prod : prod;
	end

	// One quotient bit per cycle
	logic [DIV_W:0] trial;
	logic           take;
	always_comb begin
		trial = {rem_q, dvd_q[QUO_W-1]};
		take  = (d_q != '0) && (trial >= {1'b0, d_q});
	end

	// Signed quotient added to start angle
	logic signed [ANGLE_W:0] sq, theta_sum;
	logic signed [Z_W-1:0]   z_raw;
	always_comb begin
		sq        = prod_neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		theta_sum = $signed({start_q[ANGLE_W-1], start_q}) + sq;
		z_raw     = $signed({theta_q, {(Z_W-ANGLE_W){1'b0}}});
	end

	// Gain-compensated start vector, full product width
	logic [RANGE_W+GAIN_W-1:0] x_init;
	assign x_init = range_q * GAIN_Q30;

	// CORDIC rotation step
	logic signed [XY_W-1:0] dx, dy;
	logic signed [Z_W-1:0]  atan_k;
	always_comb begin
		dx     = y_q >>> step_q;
		dy     = x_q >>> step_q;
		atan_k = $signed(Z_W'(ATAN_TAB[TAB_IDX_W'(step_q)]));
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '0;
			count_q <= COUNT_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_START_ANGLE: start_q <= $signed(cfg_data[ANGLE_W-1:0]);
				CFG_END_ANGLE:   end_q   <= $signed(cfg_data[ANGLE_W-1:0]);
				CFG_POINT_COUNT: count_q <= cfg_data[COUNT_W-1:0];
				default:         ;
			endcase
		end
	end

	// Sequencer and scan index counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			index_counter_q <= '0;
			div_cnt_q       <= '0;
			step_q          <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q         <= ST_MUL;
						index_counter_q <= s_axis_tlast ? '0 : index_counter_q + INDEX_W'(1);
					end
				end
				ST_MUL: begin
					state_q   <= ST_DIV;
					div_cnt_q <= '0;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(QUO_W - 1))
						state_q <= ST_ANG;
				end
				ST_ANG:  state_q <= ST_WRAP;
				ST_WRAP: state_q <= ST_FOLD;
				ST_FOLD: begin
					state_q <= ST_ROT;
					step_q  <= '0;
				end
				ST_ROT: begin
					if (step_q != STEP_W'(STEPS - 1))
						step_q <= step_q + STEP_W'(1);
					else if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath, no reset needed
	always_ff @(posedge clk) begin
		if (s_fire) begin
			range_q <= s_axis_tdata[RANGE_W-1:0];
			last_q  <= s_axis_tlast;
			cnt_q   <= index_counter_q;
			i_q     <= DIV_W'((cnt_ext < nm1_ext) ? cnt_ext : nm1_ext);
			d_q     <= n_m1;
		end
		unique case (state_q)
			ST_MUL: begin
				prod_neg_q <= prod[DIFF_W+DIV_W];
				rem_q      <= prod_mag[PROD_W-1:QUO_W];
				dvd_q      <= prod_mag[QUO_W-1:0];
				quo_q      <= '0;
			end
			ST_DIV: begin
				rem_q <= take ? DIV_W'(trial - {1'b0, d_q}) : trial[DIV_W-1:0];
				dvd_q <= dvd_q << 1;
				quo_q <= {quo_q[QUO_W-2:0], take};
			end
			ST_ANG: theta_q <= theta_sum[ANGLE_W-1:0];
			ST_WRAP: begin
				// bring the angle into [-pi, pi]
				if (z_raw > ANG_PI)
					z_q <= z_raw - ANG_TWO_PI;
				else if (z_raw < -ANG_PI)
					z_q <= z_raw + ANG_TWO_PI;
				else
					z_q <= z_raw;
			end
			ST_FOLD: begin
				// fold into the right half plane, negate both results later
				if (z_q > ANG_HALF_PI) begin
					z_q        <= z_q - ANG_PI;
					fold_neg_q <= 1'b1;
				end else if (z_q < -ANG_HALF_PI) begin
					z_q        <= z_q + ANG_PI;
					fold_neg_q <= 1'b1;
				end else begin
					fold_neg_q <= 1'b0;
				end
				x_q <= $signed(XY_W'(x_init));
				y_q <= '0;
			end
			ST_ROT: begin
				if (step_q != STEP_W'(STEPS - 1) || out_free) begin
					if (!z_q[Z_W-1]) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - atan_k;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + atan_k;
					end
				end
			end
			default: ;
		endcase
	end

	// Output register: final rotation feeds rounding directly
	logic signed [XY_W-1:0] x_fin, y_fin;
	always_comb begin
		if (!z_q[Z_W-1]) begin
			x_fin = x_q - dx;
			y_fin = y_q + dy;
		end else begin
			x_fin = x_q + dx;
			y_fin = y_q - dy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (out_load)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_x_q    <= to_out(x_fin, fold_neg_q);
			m_y_q    <= to_out(y_fin, fold_neg_q);
			m_idx_q  <= cnt_q;
			m_last_q <= last_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, m_idx_q, m_y_q, m_x_q};
	assign m_axis_tlast  = m_last_q;

endmodule
